// ----- src/tun_pkg.sv -----
// Package: shared constants for the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int CoordWidthDef  = 16;
  localparam int FracBitsDef    = 14;
  localparam int OutWidth       = 16;
  localparam int MagWidth       = 31;
  localparam int SumWidth       = 64;
  localparam int RootWidth      = 32;
  localparam int QuoWidth       = FracBitsDef + 2;
endpackage

// ----- src/tun_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module tun_sqrt #(
  parameter int SumW  = tun_pkg::SumWidth,
  parameter int SideW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [SumW-1:0]      in_sum,
  input  logic [SideW-1:0]     in_side,
  output logic                 out_vld,
  output logic [SumW/2-1:0]    out_root,
  output logic [SideW-1:0]     out_side
);
  localparam int N = SumW / 2;

  logic [SumW-1:0]  rem_r  [N+1];
  logic [N-1:0]     root_r [N+1];
  logic [SideW-1:0] side_r [N+1];
  logic [N:0]       vld_r;

  always_comb begin
    rem_r[0]  = in_sum;
    root_r[0] = '0;
    side_r[0] = in_side;
    vld_r[0]  = in_vld;
  end

  for (genvar k = 0; k < N; k++) begin : g_stg
    localparam int B = N - 1 - k;
    logic [SumW+1:0] trial;
    logic [SumW+1:0] rem_ext;
    always_comb begin
      trial   = ({2'b00, (SumW)'(root_r[k])} << (B + 1)) | ((SumW+2)'(1) << (2 * B));
      rem_ext = {2'b00, rem_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (adv) begin
        side_r[k+1] <= side_r[k];
        if (rem_ext >= trial) begin
          rem_r[k+1]  <= SumW'(rem_ext - trial);
          root_r[k+1] <= root_r[k] | (N'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];
endmodule

// ----- src/tun_div.sv -----
// Pipelined restoring divider for one normal component, one quotient bit per stage.
`timescale 1ns / 1ps
module tun_div #(
  parameter int NumW = 46,
  parameter int DenW = tun_pkg::RootWidth,
  parameter int QW   = tun_pkg::QuoWidth
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [QW-1:0]   quo
);
  // num < 2^(QW-1) * den * 2 holds since m <= r+1, so QW quotient bits suffice
  logic [NumW-1:0] rem_r [QW+1];
  logic [DenW-1:0] den_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];

  always_comb begin
    rem_r[0] = num;
    den_r[0] = den;
    q_r[0]   = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stg
    localparam int B = QW - 1 - k;
    logic [NumW+QW:0] dsh;
    always_comb dsh = {{(QW+1){1'b0}}, NumW'(den_r[k])} << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k+1] <= den_r[k];
        if ({{(QW+1){1'b0}}, rem_r[k]} >= dsh) begin
          rem_r[k+1] <= NumW'({{(QW+1){1'b0}}, rem_r[k]} - dsh);
          q_r[k+1]   <= q_r[k] | (QW'(1) << B);
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  assign quo = q_r[QW];
endmodule

// ----- src/triangle_unit_normal.sv -----
// Top level: triangle face unit normal, fully pipelined.
//
//  channel | ports                              | handshake
//  in      | in_first_*..in_third_*, face_last  | in_valid / in_stall
//  out     | out_normal_*, degenerate, last     | out_valid / out_stall
//
// One face enters per cycle while no valid output is stalled. The stages are
// edge/product, cross-product, block-scale and square stages, 32 square-root
// stages, one numerator stage, one divider stage per quotient bit, then
// saturation in the output register.
// Reset clears only the valid bits. A stall on a valid output freezes the
// whole pipeline; while the output holds nothing, the stages keep advancing.
`timescale 1ns / 1ps
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = tun_pkg::CoordWidthDef,
  parameter int NORMAL_FRAC_BITS = tun_pkg::FracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_z,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_z,
  input  logic signed [COORD_WIDTH-1:0] in_third_x,
  input  logic signed [COORD_WIDTH-1:0] in_third_y,
  input  logic signed [COORD_WIDTH-1:0] in_third_z,
  input  logic                          in_face_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_normal_x,
  output logic signed [15:0]            out_normal_y,
  output logic signed [15:0]            out_normal_z,
  output logic                          out_degenerate,
  output logic                          out_face_last_out
);
  localparam int EW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * EW;
  localparam int AW   = PW + 1;
  localparam int MW   = tun_pkg::MagWidth;
  localparam int SW   = tun_pkg::SumWidth;
  localparam int RW   = SW / 2;
  localparam int QW   = NORMAL_FRAC_BITS + 2;
  localparam int NW   = MW + NORMAL_FRAC_BITS + 1;
  localparam int LW   = $clog2(AW + 1);
  localparam int DEPTH_DIV = QW;

  // Pipeline advances unless a valid result waits under stall.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: edges and the six products.
  logic signed [EW-1:0] e2_x, e2_y, e2_z, e3_x, e3_y, e3_z;
  always_comb begin
    e2_x = EW'(in_second_x) - EW'(in_first_x);
    e2_y = EW'(in_second_y) - EW'(in_first_y);
    e2_z = EW'(in_second_z) - EW'(in_first_z);
    e3_x = EW'(in_third_x) - EW'(in_first_x);
    e3_y = EW'(in_third_y) - EW'(in_first_y);
    e3_z = EW'(in_third_z) - EW'(in_first_z);
  end

  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic                 v1_r, l1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      p0_r <= PW'(e2_y) * PW'(e3_z);
      p1_r <= PW'(e2_z) * PW'(e3_y);
      p2_r <= PW'(e2_z) * PW'(e3_x);
      p3_r <= PW'(e2_x) * PW'(e3_z);
      p4_r <= PW'(e2_x) * PW'(e3_y);
      p5_r <= PW'(e2_y) * PW'(e3_x);
      l1_r <= in_face_last_in;
    end
  end

  // Stage 2: cross product magnitudes and signs.
  logic signed [AW-1:0] ax, ay, az;
  always_comb begin
    ax = AW'(p0_r) - AW'(p1_r);
    ay = AW'(p2_r) - AW'(p3_r);
    az = AW'(p4_r) - AW'(p5_r);
  end

  logic [AW-1:0] mx_r, my_r, mz_r;
  logic [2:0]    s2_r;
  logic          v2_r, l2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      mx_r <= ax[AW-1] ? AW'(-ax) : AW'(ax);
      my_r <= ay[AW-1] ? AW'(-ay) : AW'(ay);
      mz_r <= az[AW-1] ? AW'(-az) : AW'(az);
      s2_r <= {az[AW-1], ay[AW-1], ax[AW-1]};
      l2_r <= l1_r;
    end
  end

  // Stage 3: block scale to 31 bits by leading-one position of the OR.
  logic [AW-1:0] orv;
  logic [LW-1:0] len;
  logic [LW-1:0] sh;
  always_comb begin
    orv = mx_r | my_r | mz_r;
    len = '0;
    for (int i = 0; i < AW; i++) begin
      if (orv[i]) len = LW'(i + 1);
    end
    sh = (len > LW'(MW)) ? LW'(len - LW'(MW)) : '0;
  end

  logic [MW-1:0] m3x_r, m3y_r, m3z_r;
  logic [2:0]    s3_r;
  logic          v3_r, l3_r, d3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      m3x_r <= MW'(mx_r >> sh);
      m3y_r <= MW'(my_r >> sh);
      m3z_r <= MW'(mz_r >> sh);
      s3_r  <= s2_r;
      l3_r  <= l2_r;
      d3_r  <= (orv == '0);
    end
  end

  // Stage 4: squares.
  logic [2*MW-1:0] qx_r, qy_r, qz_r;
  logic [MW-1:0]   m4x_r, m4y_r, m4z_r;
  logic [2:0]      s4_r;
  logic            v4_r, l4_r, d4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      qx_r  <= (2*MW)'(m3x_r) * (2*MW)'(m3x_r);
      qy_r  <= (2*MW)'(m3y_r) * (2*MW)'(m3y_r);
      qz_r  <= (2*MW)'(m3z_r) * (2*MW)'(m3z_r);
      m4x_r <= m3x_r;
      m4y_r <= m3y_r;
      m4z_r <= m3z_r;
      s4_r  <= s3_r;
      l4_r  <= l3_r;
      d4_r  <= d3_r;
    end
  end

  logic [SW-1:0] sum;
  assign sum = SW'(qx_r) + SW'(qy_r) + SW'(qz_r);

  // Square root; magnitudes and flags ride along as side data.
  localparam int SDW = 3 * MW + 5;
  logic [SDW-1:0] sq_side, sq_side_o;
  logic [RW-1:0]  root;
  logic           v5;
  assign sq_side = {m4x_r, m4y_r, m4z_r, s4_r, l4_r, d4_r};

  tun_sqrt #(.SumW(SW), .SideW(SDW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(v4_r), .in_sum(sum), .in_side(sq_side),
    .out_vld(v5), .out_root(root), .out_side(sq_side_o)
  );

  logic [MW-1:0] m5x, m5y, m5z;
  logic [2:0]    s5;
  logic          l5, d5;
  assign {m5x, m5y, m5z, s5, l5, d5} = sq_side_o;

  // Stage: build rounded numerators; a degenerate face divides by one.
  logic [NW-1:0] n6x_r, n6y_r, n6z_r;
  logic [RW-1:0] r6_r;
  logic [2:0]    s6_r;
  logic          v6_r, l6_r, d6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5;
    end
    if (adv) begin
      n6x_r <= (NW'(m5x) << NORMAL_FRAC_BITS) + NW'(root >> 1);
      n6y_r <= (NW'(m5y) << NORMAL_FRAC_BITS) + NW'(root >> 1);
      n6z_r <= (NW'(m5z) << NORMAL_FRAC_BITS) + NW'(root >> 1);
      r6_r  <= d5 ? RW'(1) : root;
      s6_r  <= s5;
      l6_r  <= l5;
      d6_r  <= d5;
    end
  end

  logic [QW-1:0] qox, qoy, qoz;
  tun_div #(.NumW(NW), .DenW(RW), .QW(QW)) u_div_x (
    .clk(clk), .adv(adv), .num(n6x_r), .den(r6_r), .quo(qox));
  tun_div #(.NumW(NW), .DenW(RW), .QW(QW)) u_div_y (
    .clk(clk), .adv(adv), .num(n6y_r), .den(r6_r), .quo(qoy));
  tun_div #(.NumW(NW), .DenW(RW), .QW(QW)) u_div_z (
    .clk(clk), .adv(adv), .num(n6z_r), .den(r6_r), .quo(qoz));

  // Flags delay line matching the divider depth.
  logic [DEPTH_DIV:0] dv_r;
  logic [4:0]         df_r [DEPTH_DIV+1];
  always_comb begin
    dv_r[0] = v6_r;
    df_r[0] = {s6_r, l6_r, d6_r};
  end
  for (genvar k = 0; k < DEPTH_DIV; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (adv) df_r[k+1] <= df_r[k];
    end
  end

  logic [2:0] s7;
  logic       l7, d7;
  assign {s7, l7, d7} = df_r[DEPTH_DIV];

  function automatic logic [15:0] fin(input logic [QW-1:0] q, input logic neg,
                                      input logic deg);
    logic [QW-1:0] one;
    logic [QW-1:0] sat;
    logic [15:0]   v;
    one = QW'(1) << NORMAL_FRAC_BITS;
    sat = (q > one) ? one : q;
    v   = 16'(sat);
    if (deg) v = '0;
    else if (neg) v = 16'(-v);
    return v;
  endfunction

  // Output register.
  logic                   ov_r;
  logic signed [15:0]     nx_r, ny_r, nz_r;
  logic                   dg_r, lo_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[DEPTH_DIV];
    end
    if (adv) begin
      nx_r <= fin(qox, s7[0], d7);
      ny_r <= fin(qoy, s7[1], d7);
      nz_r <= fin(qoz, s7[2], d7);
      dg_r <= d7;
      lo_r <= l7;
    end
  end

  assign out_valid         = ov_r;
  assign out_normal_x      = nx_r;
  assign out_normal_y      = ny_r;
  assign out_normal_z      = nz_r;
  assign out_degenerate    = dg_r;
  assign out_face_last_out = lo_r;

  localparam logic [15:0] ONE16 = 16'(1 << NORMAL_FRAC_BITS);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate face with nonzero normal");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_stall && out_valid |-> in_stall)
    else $error("pipeline advanced while output held");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      ($signed(out_normal_x) <= $signed(ONE16)) && ($signed(out_normal_x) >= -$signed(ONE16)))
    else $error("normal x out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) && rst_n && $past(rst_n) |-> out_valid && $stable(out_normal_z))
    else $error("stalled result changed");
endmodule

// ----- dv/testbench.sv -----
// Testbench for triangle_unit_normal: directed faces and random faces checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  localparam int CW = tun_pkg::CoordWidthDef;
  localparam int FB = tun_pkg::FracBitsDef;
  localparam int LATENCY = 3 + 32 + 1 + FB + 2 + 4;

  typedef struct packed {
    logic signed [CW-1:0] p1x, p1y, p1z, p2x, p2y, p2z, p3x, p3y, p3z;
    logic                 last;
  } face_t;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic        degen;
    logic        last;
  } normal_t;

  typedef struct {
    face_t   face;
    bit      typed;
    normal_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  face_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate, out_face_last_out;

  normal_t expected_normals[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_unit_normal u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_x(drv.p1x), .in_first_y(drv.p1y), .in_first_z(drv.p1z),
    .in_second_x(drv.p2x), .in_second_y(drv.p2y), .in_second_z(drv.p2z),
    .in_third_x(drv.p3x), .in_third_y(drv.p3y), .in_third_z(drv.p3z),
    .in_face_last_in(drv.last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate),
    .out_face_last_out(out_face_last_out)
  );

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(input face_t f);
    logic signed [CW+1:0] e2x, e2y, e2z, e3x, e3y, e3z;
    logic signed [2*CW+5:0] a[3];
    logic [2*CW+5:0] am[3];
    logic [63:0] m[3], s, r, q;
    int len, sh;
    normal_t n;
    e2x = (CW+2)'(f.p2x) - (CW+2)'(f.p1x);
    e2y = (CW+2)'(f.p2y) - (CW+2)'(f.p1y);
    e2z = (CW+2)'(f.p2z) - (CW+2)'(f.p1z);
    e3x = (CW+2)'(f.p3x) - (CW+2)'(f.p1x);
    e3y = (CW+2)'(f.p3y) - (CW+2)'(f.p1y);
    e3z = (CW+2)'(f.p3z) - (CW+2)'(f.p1z);
    a[0] = (2*CW+6)'(e2y) * (2*CW+6)'(e3z) - (2*CW+6)'(e2z) * (2*CW+6)'(e3y);
    a[1] = (2*CW+6)'(e2z) * (2*CW+6)'(e3x) - (2*CW+6)'(e2x) * (2*CW+6)'(e3z);
    a[2] = (2*CW+6)'(e2x) * (2*CW+6)'(e3y) - (2*CW+6)'(e2y) * (2*CW+6)'(e3x);
    len = 0;
    for (int i = 0; i < 3; i++) begin
      am[i] = a[i] < 0 ? -a[i] : a[i];
      for (int b = 0; b < 2 * CW + 6; b++) if (am[i][b] && b + 1 > len) len = b + 1;
    end
    n = '0;
    n.last = f.last;
    if (len == 0) begin
      n.degen = 1'b1;
      return n;
    end
    sh = len > 31 ? len - 31 : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 64'(am[i] >> sh);
      s = s + m[i] * m[i];
    end
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (r >> 1)) / r;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      if (a[i] < 0) q = -q;
      if (i == 0) n.nx = q[15:0];
      else if (i == 1) n.ny = q[15:0];
      else n.nz = q[15:0];
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Result side: stall at random, check every transfer.
  always @(posedge clk) begin
    normal_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected result", 16'(out_normal_x), 16'h0);
        end else begin
          want = expected_normals.pop_front();
          if (out_normal_x !== want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
          if (out_normal_y !== want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
          if (out_normal_z !== want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
          if (out_degenerate !== want.degen)
            report_mismatch("degenerate", 16'(out_degenerate), 16'(want.degen));
          if (out_face_last_out !== want.last)
            report_mismatch("face_last", 16'(out_face_last_out), 16'(want.last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic face_t random_face();
    face_t f;
    int kind;
    f = face_t'((10 * CW + 1)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom}));
    kind = $urandom_range(9);
    // collinear or repeated vertices now and then
    if (kind == 0) begin
      f.p2x = f.p1x; f.p2y = f.p1y; f.p2z = f.p1z;
    end else if (kind == 1) begin
      f.p3x = f.p2x; f.p3y = f.p2y; f.p3z = f.p2z;
    end else if (kind < 5) begin
      // small faces near a random origin
      f.p2x = CW'(f.p1x + $signed(CW'($urandom_range(15))) - 8);
      f.p2y = CW'(f.p1y + $signed(CW'($urandom_range(15))) - 8);
      f.p2z = CW'(f.p1z + $signed(CW'($urandom_range(15))) - 8);
      f.p3x = CW'(f.p1x + $signed(CW'($urandom_range(15))) - 8);
      f.p3y = CW'(f.p1y + $signed(CW'($urandom_range(15))) - 8);
      f.p3z = CW'(f.p1z + $signed(CW'($urandom_range(15))) - 8);
    end
    return f;
  endfunction

  task automatic send_face(input face_t f, input normal_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= f;
    expected_normals.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    face_t f;
    localparam logic signed [CW-1:0] MX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MN = {1'b1, {(CW-1){1'b0}}};
    // degenerate: all zero
    rows.push_back('{face_t'('0), 1'b1, normal_t'({16'h0, 16'h0, 16'h0, 1'b1, 1'b0})});
    // unit triangle in the xy plane: normal +z
    f = '0; f.p2x = 1; f.p3y = 1; f.last = 1'b1;
    rows.push_back('{f, 1'b1, normal_t'({16'h0, 16'h0, 16'h4000, 1'b0, 1'b1})});
    // swapped winding: normal -z
    f = '0; f.p2y = 1; f.p3x = 1;
    rows.push_back('{f, 1'b1, normal_t'({16'h0, 16'h0, 16'hC000, 1'b0, 1'b0})});
    // yz plane: +x
    f = '0; f.p2y = 1; f.p3z = 1;
    rows.push_back('{f, 1'b1, normal_t'({16'h4000, 16'h0, 16'h0, 1'b0, 1'b0})});
    // zx plane: +y
    f = '0; f.p2z = 1; f.p3x = 1;
    rows.push_back('{f, 1'b1, normal_t'({16'h0, 16'h4000, 16'h0, 1'b0, 1'b0})});
    // collinear extremes: degenerate
    f = '0; f.p1x = MN; f.p1y = MN; f.p1z = MN; f.p2x = MX; f.p2y = MX; f.p2z = MX;
    f.p3x = MN; f.p3y = MN; f.p3z = MN; f.last = 1'b1;
    rows.push_back('{f, 1'b1, normal_t'({16'h0, 16'h0, 16'h0, 1'b1, 1'b1})});
    // largest edges, forcing block scaling
    f = '0; f.p1x = MN; f.p1y = MN; f.p1z = MN; f.p2x = MX; f.p2y = MN; f.p2z = MN;
    f.p3x = MN; f.p3y = MX; f.p3z = MN;
    rows.push_back('{f, 1'b1, normal_t'({16'h0, 16'h0, 16'h4000, 1'b0, 1'b0})});
    f = '0; f.p1x = MX; f.p1y = MN; f.p1z = MX; f.p2x = MN; f.p2y = MX; f.p2z = MN;
    f.p3x = MX; f.p3y = MX; f.p3z = MN;
    rows.push_back('{f, 1'b0, normal_t'('0)});
    f = '0; f.p1x = MN; f.p2y = MX; f.p3z = MX; f.p2x = MX; f.p3y = MN; f.p1z = MN;
    rows.push_back('{f, 1'b0, normal_t'('0)});
    // diagonal faces where rounding may overshoot one
    f = '0; f.p2x = 1; f.p2y = -1; f.p3y = 1; f.p3z = -1;
    rows.push_back('{f, 1'b0, normal_t'('0)});
    f = '0; f.p2x = 3; f.p3y = 4; f.p3z = 5; f.p1x = -1;
    rows.push_back('{f, 1'b0, normal_t'('0)});
    f = face_t'({(10 * CW + 1){1'b1}});
    rows.push_back('{f, 1'b0, normal_t'('0)});
    f = '0; f.p1x = MX; f.p1y = MX; f.p1z = MX; f.p2x = MX; f.p3y = MX; f.last = 1'b1;
    rows.push_back('{f, 1'b0, normal_t'('0)});
    f = '0; f.p2x = MX; f.p2y = 1; f.p3x = 1; f.p3y = MX; f.p3z = MN;
    rows.push_back('{f, 1'b0, normal_t'('0)});

    drv <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].typed && face_normal(rows[i].face) !== rows[i].want)
        $display("directed row %0d table entry disagrees with predictor", i);
      send_face(rows[i].face, rows[i].typed ? rows[i].want : face_normal(rows[i].face));
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 400; n++) begin
        f = random_face();
        send_face(f, face_normal(f));
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    if (!done) begin
      $display("*** FAILED ***");
      $finish;
    end
  end
endmodule
